/* hdl/slie_pkg.sv */
// ----------------------------------------------------------------------------
// Shifting list package
// Shared constants, operation and status codes, and transaction types.
// ----------------------------------------------------------------------------
package slie_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned NUM_GRP  = DEPTH / GRP_SIZE;
  localparam int unsigned SEL_W    = $clog2(GRP_SIZE);
  localparam int unsigned GRP_W    = $clog2(NUM_GRP);

  typedef enum logic [KIND_W-1:0] {
    K_SET    = 3'd0,
    K_GET    = 3'd1,
    K_PUSH   = 3'd2,
    K_INSERT = 3'd3,
    K_ERASE  = 3'd4,
    K_RESIZE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic [LEN_W-1:0]         new_length;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic                     wr;
    logic [LEN_W-1:0]         wr_pos;
    logic                     shift_up;
    logic                     shift_dn;
    logic                     fill;
    logic [LEN_W-1:0]         lo;
    logic [LEN_W-1:0]         hi;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

/* hdl/slie_cell.sv */
// ----------------------------------------------------------------------------
// Shifting list cell
// One list entry that writes, takes a neighbor's value, or clears.
// ----------------------------------------------------------------------------
module slie_cell
  import slie_pkg::*;
(
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic [LEN_W-1:0]         pos_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] value_o
);

  logic signed [DATA_W-1:0] value_d, value_q;
  logic [LEN_W-1:0]         pos_next;

  assign pos_next = LEN_W'(pos_i + LEN_W'(1));

  always_comb begin
    value_d = value_q;
    if (cmd_i.wr && pos_i == cmd_i.wr_pos) begin
      value_d = cmd_i.value;
    end else if (cmd_i.shift_up && pos_i > cmd_i.lo && pos_i <= cmd_i.hi) begin
      value_d = left_i;
    end else if (cmd_i.shift_dn && pos_i >= cmd_i.lo && pos_next < cmd_i.hi) begin
      value_d = right_i;
    end else if (cmd_i.fill && pos_i >= cmd_i.lo && pos_i < cmd_i.hi) begin
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* hdl/shifting_list_insert_erase_top.sv */
// ----------------------------------------------------------------------------
// Shifting list with insert and erase
// A row of cells holding an ordered list of signed 32-bit values.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (valid/ready) as one transaction each:
// set, get, push back, insert, erase or resize. Every request gives exactly
// one response transaction on the out channel with the value read, the
// length after the operation and a status.
// All cells update in parallel in the cycle a request is accepted; insert
// and erase move each affected entry one place along the row.
// A get reads through a registered two-level select: eight groups of eight
// cells, then one group. The response passes from the select register to
// the output register, and the block takes no new request while the select
// register holds one.
// Reset empties the list (length zero); cell contents are not cleared and
// an entry is only readable after it has been written.
// When the receiver stalls, the response waits in the output register and
// one more request can complete into the select stage; after that the input
// ready stays low until the output drains.
// ----------------------------------------------------------------------------
module shifting_list_insert_erase_top
  import slie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic                     accept;
  logic [LEN_W-1:0]         count_d, count_q;
  logic [LEN_W-1:0]         idx_ext;
  logic                     idx_in_list, idx_at_most_len, list_full;
  status_e                  status;
  logic                     op_ok;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic signed [DATA_W-1:0] grp_d [NUM_GRP];
  logic signed [DATA_W-1:0] grp_q [NUM_GRP];

  logic                     s1_valid_q;
  logic                     s1_get_q;
  logic [GRP_W-1:0]         s1_grp_q;
  logic [LEN_W-1:0]         s1_len_q;
  status_e                  s1_st_q;
  logic                     s1_move;
  logic                     out_valid_q;
  rsp_t                     out_q;

  assign accept          = in_valid_i && in_ready_o;
  assign in_ready_o      = !s1_valid_q;
  assign idx_ext         = LEN_W'(in_data_i.index);
  assign idx_in_list     = idx_ext < count_q;
  assign idx_at_most_len = idx_ext <= count_q;
  assign list_full       = count_q >= LEN_W'(DEPTH);

  always_comb begin
    status  = ST_OK;
    count_d = count_q;
    case (in_data_i.kind)
      K_SET, K_GET: begin
        if (!idx_in_list) status = ST_RANGE;
      end
      K_PUSH: begin
        if (list_full) status = ST_FULL;
        else count_d = LEN_W'(count_q + LEN_W'(1));
      end
      K_INSERT: begin
        if (!idx_at_most_len) status = ST_RANGE;
        else if (list_full) status = ST_FULL;
        else count_d = LEN_W'(count_q + LEN_W'(1));
      end
      K_ERASE: begin
        if (!idx_in_list) status = ST_RANGE;
        else count_d = LEN_W'(count_q - LEN_W'(1));
      end
      K_RESIZE: begin
        if (in_data_i.new_length > LEN_W'(DEPTH)) status = ST_FULL;
        else count_d = in_data_i.new_length;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign op_ok = accept && (status == ST_OK);

  always_comb begin
    cmd       = '0;
    cmd.value = in_data_i.value;
    if (op_ok) begin
      case (in_data_i.kind)
        K_SET: begin
          cmd.wr     = 1'b1;
          cmd.wr_pos = idx_ext;
        end
        K_PUSH: begin
          cmd.wr     = 1'b1;
          cmd.wr_pos = count_q;
        end
        K_INSERT: begin
          cmd.wr       = 1'b1;
          cmd.wr_pos   = idx_ext;
          cmd.shift_up = 1'b1;
          cmd.lo       = idx_ext;
          cmd.hi       = count_q;
        end
        K_ERASE: begin
          cmd.shift_dn = 1'b1;
          cmd.lo       = idx_ext;
          cmd.hi       = count_q;
        end
        K_RESIZE: begin
          cmd.fill = 1'b1;
          cmd.lo   = count_q;
          cmd.hi   = in_data_i.new_length;
        end
        default: begin
          cmd.wr = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[i+1];
    end
    slie_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (LEN_W'(i)),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_d[g] = cell_val[{GRP_W'(g), in_data_i.index[SEL_W-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q    <= grp_d;
      s1_get_q <= (in_data_i.kind == K_GET) && (status == ST_OK);
      s1_grp_q <= in_data_i.index[IDX_W-1:SEL_W];
      s1_len_q <= count_d;
      s1_st_q  <= status;
    end
  end

  assign s1_move = s1_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_ok) count_q <= count_d;
      if (accept) s1_valid_q <= 1'b1;
      else if (s1_move) s1_valid_q <= 1'b0;
      if (s1_move) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.read_value <= s1_get_q ? grp_q[s1_grp_q] : '0;
      out_q.length     <= s1_len_q;
      out_q.status     <= s1_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LEN_W'(DEPTH))
    else $error("List length exceeds the capacity.");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q && !in_ready_o)
    else $error("Accepted transaction did not reach the select stage.");

  a_fail_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_value == '0)
    else $error("Failed transaction returned a nonzero value.");

  a_length_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.kind != K_RESIZE |=>
      count_q == $past(count_q) || count_q == LEN_W'($past(count_q) + LEN_W'(1))
      || count_q == LEN_W'($past(count_q) - LEN_W'(1)))
    else $error("Length moved by more than one outside a resize.");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shifting list testbench
// Drives list operations into the block and checks every response against
// a behavioral copy of the list. Directed tests cover empty-list faults,
// shifting on insert and erase, capacity limits and resize. Random traffic
// then runs under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import slie_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  logic signed [DATA_W-1:0] list_cells [DEPTH];
  int unsigned list_len = 0;
  rsp_t pending_results [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stuck_cycles = 0;

  shifting_list_insert_erase_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic rsp_t list_apply(input req_t r);
    rsp_t res;
    int i;
    res.read_value = '0;
    res.status = ST_OK;
    case (r.kind)
      K_SET: begin
        if (r.index < list_len) list_cells[r.index] = r.value;
        else res.status = ST_RANGE;
      end
      K_GET: begin
        if (r.index < list_len) res.read_value = list_cells[r.index];
        else res.status = ST_RANGE;
      end
      K_PUSH: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_cells[IDX_W'(list_len)] = r.value;
          list_len++;
        end
      end
      K_INSERT: begin
        if (r.index > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > r.index; i--) begin
            list_cells[IDX_W'(i)] = list_cells[IDX_W'(i-1)];
          end
          list_cells[r.index] = r.value;
          list_len++;
        end
      end
      K_ERASE: begin
        if (r.index < list_len) begin
          for (i = r.index + 1; i < list_len; i++) begin
            list_cells[IDX_W'(i-1)] = list_cells[IDX_W'(i)];
          end
          list_len--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      K_RESIZE: begin
        if (r.new_length > DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i < r.new_length; i++) list_cells[IDX_W'(i)] = '0;
          list_len = 32'(r.new_length);
        end
      end
      default: ;
    endcase
    res.length = list_len[LEN_W-1:0];
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request(input bit grow);
    req_t r;
    int unsigned pick;
    int unsigned top;
    r.kind = K_GET;
    r.index = IDX_W'($urandom);
    r.value = pick_value();
    r.new_length = LEN_W'($urandom);
    if ($urandom_range(99) < 3) begin
      r.kind = KIND_W'($urandom);
      return r;
    end
    pick = $urandom_range(99);
    if (grow) begin
      if (pick < 25) r.kind = K_PUSH;
      else if (pick < 50) r.kind = K_INSERT;
      else if (pick < 70) r.kind = K_GET;
      else if (pick < 82) r.kind = K_SET;
      else if (pick < 92) r.kind = K_ERASE;
      else if (pick < 97) r.kind = K_RESIZE;
      else r.kind = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
    end else begin
      if (pick < 8) r.kind = K_PUSH;
      else if (pick < 18) r.kind = K_INSERT;
      else if (pick < 38) r.kind = K_GET;
      else if (pick < 50) r.kind = K_SET;
      else if (pick < 85) r.kind = K_ERASE;
      else if (pick < 95) r.kind = K_RESIZE;
      else r.kind = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
    end
    if ($urandom_range(9) != 0) begin
      if (r.kind == K_INSERT) begin
        top = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;
        r.index = IDX_W'($urandom_range(top));
      end else if (list_len > 0) begin
        r.index = IDX_W'($urandom_range(list_len - 1));
      end
    end
    if (r.kind == K_RESIZE) begin
      case ($urandom_range(9))
        0: r.new_length = LEN_W'($urandom_range(127));
        1: r.new_length = LEN_W'(DEPTH);
        default: r.new_length = grow ? LEN_W'($urandom_range(DEPTH, list_len))
                                      : LEN_W'($urandom_range(list_len, 0));
      endcase
    end
    return r;
  endfunction

  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), list_apply(item));
  endtask

  task automatic send_op(input logic [KIND_W-1:0] kind, input int unsigned index,
                         input logic signed [DATA_W-1:0] value, input int unsigned nlen);
    req_t r;
    r.kind = kind;
    r.index = IDX_W'(index);
    r.value = value;
    r.new_length = LEN_W'(nlen);
    send_item(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_empty_list_errors();
    send_op(K_GET, 0, 0, 0);
    send_op(K_SET, 5, 32'sd17, 0);
    send_op(K_ERASE, 0, 0, 0);
    send_op(K_INSERT, 1, 32'sd3, 0);
    send_op(KIND_SPARE_6, 63, -32'sd1, 127);
    send_op(KIND_SPARE_7, 0, 0, 0);
  endtask

  task automatic test_insert_erase_shift();
    send_op(K_INSERT, 0, 32'sh7fff_ffff, 0);
    send_op(K_PUSH, 0, 32'sh8000_0000, 0);
    send_op(K_INSERT, 1, -32'sd1, 0);
    send_op(K_INSERT, 3, 32'sd1, 0);
    send_op(K_SET, 2, 32'sh5555_5555, 0);
    send_op(K_ERASE, 0, 0, 0);
    send_op(K_ERASE, 2, 0, 0);
    send_op(K_GET, 0, 0, 0);
    send_op(K_GET, 1, 0, 0);
  endtask

  task automatic test_capacity_limits();
    send_op(K_RESIZE, 0, 0, 127);
    send_op(K_RESIZE, 0, 0, DEPTH + 1);
    send_op(K_RESIZE, 0, 0, DEPTH);
    send_op(K_PUSH, 0, 32'sd9, 0);
    send_op(K_INSERT, 63, 32'sd9, 0);
    send_op(K_SET, 6, -32'sd1, 0);
  endtask

  task automatic test_resize_shrink_grow();
    send_op(K_RESIZE, 0, 0, 5);
    send_op(K_GET, 5, 0, 0);
    send_op(K_RESIZE, 0, 0, 7);
    send_op(K_GET, 6, 0, 0);
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    bit grow;
    grow = 1'b1;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (grow && list_len == DEPTH && $urandom_range(9) == 0) grow = 1'b0;
      else if (!grow && list_len == 0) grow = 1'b1;
      else if ($urandom_range(79) == 0) grow = !grow;
      send_item(random_request(grow));
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("response transaction with no request outstanding");
        fail_count++;
      end else begin
        exp_rsp = pending_results.pop_front();
        if (out_data_o.read_value !== exp_rsp.read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d",
                 exp_rsp.read_value, out_data_o.read_value);
          fail_count++;
        end
        if (out_data_o.length !== exp_rsp.length) begin
          $error("length mismatch: expected %0d, actual %0d",
                 exp_rsp.length, out_data_o.length);
          fail_count++;
        end
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 exp_rsp.status, out_data_o.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list_errors();
    test_insert_erase_shift();
    test_capacity_limits();
    test_resize_shrink_grow();
    wait_drained();
    test_random_traffic(256, 0, 0);
    test_random_traffic(256, 58, 0);
    test_random_traffic(256, 0, 58);
    test_random_traffic(256, 9, 9);
    if (pending_results.size() != 0) begin
      $error("%0d expected responses never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/slie_pkg.sv
hdl/slie_cell.sv
hdl/shifting_list_insert_erase_top.sv
tb/tb_top.sv
